[design/bbit_pkg.sv]
`default_nettype none

package bbit_pkg;

    // Geometry of the tracker.
    localparam int EDGE_TOTAL = 4;
    localparam int EDGE_W     = 2;
    localparam int LEVEL_W    = 8;
    localparam int RUN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // Item commands.
    localparam logic CMD_PLAN    = 1'b0;
    localparam logic CMD_CAPTURE = 1'b1;

    // Edge codes.
    localparam logic [EDGE_W-1:0] SIDE_TOP    = 2'd0;
    localparam logic [EDGE_W-1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [EDGE_W-1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [EDGE_W-1:0] SIDE_LEFT   = 2'd3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK_THRESHOLD   = 3'd0,
        REG_CONTENT_THRESHOLD = 3'd1,
        REG_INITIAL_STREAK    = 3'd2,
        REG_WALKING_STREAK    = 3'd3,
        REG_STEP_SIZE         = 3'd4,
        REG_ROW_LIMIT         = 3'd5,
        REG_COLUMN_LIMIT      = 3'd6,
        REG_PROBE_PERIOD      = 3'd7
    } t_reg_idx;

    // Reset values of the configuration registers.
    localparam logic [7:0]       RST_BLACK_THRESHOLD   = 8'd12;
    localparam logic [7:0]       RST_CONTENT_THRESHOLD = 8'd40;
    localparam logic [RUN_W-1:0] RST_INITIAL_STREAK    = 6'd45;
    localparam logic [RUN_W-1:0] RST_WALKING_STREAK    = 6'd4;
    localparam logic [7:0]       RST_STEP_SIZE         = 8'd16;
    localparam logic [7:0]       RST_ROW_LIMIT         = 8'd160;
    localparam logic [7:0]       RST_COLUMN_LIMIT      = 8'd192;
    localparam logic [7:0]       RST_PROBE_PERIOD      = 8'd64;

    typedef struct packed {
        logic [7:0]       black_threshold;
        logic [7:0]       content_threshold;
        logic [RUN_W-1:0] initial_streak;
        logic [RUN_W-1:0] walking_streak;
        logic [7:0]       step_size;
        logic [7:0]       row_limit;
        logic [7:0]       column_limit;
        logic [7:0]       probe_period;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [EDGE_W-1:0] edge_req;
        logic              probe_flag;
        logic [7:0]        peak_level;
    } t_item;

    typedef struct packed {
        logic       probe_now;
        logic [7:0] capture_inset;
        logic       discard;
        logic [7:0] inset_now;
    } t_result;

    // Tracking state kept for one edge.
    typedef struct packed {
        logic [7:0]         inset;
        logic [RUN_W-1:0]   run;
        logic               walking;
        logic [LEVEL_W-1:0] level;
        logic [7:0]         count;
    } t_edge_state;

    typedef t_edge_state [EDGE_TOTAL-1:0] t_edge_vec;

endpackage

`default_nettype wire

[design/bbit_if.sv]
`default_nettype none

// Channel that carries one input word.
interface bbit_item_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [bbit_pkg::EDGE_W-1:0] edge_req;
    logic                        probe_flag;
    logic [7:0]                  peak_level;

    modport source (output valid, cmd, edge_req, probe_flag, peak_level, input ready);
    modport sink   (input valid, cmd, edge_req, probe_flag, peak_level, output ready);
endinterface

// Channel that carries one result word.
interface bbit_result_if;
    logic       valid;
    logic       ready;
    logic       probe_now;
    logic [7:0] capture_inset;
    logic       discard;
    logic [7:0] inset_now;

    modport source (output valid, probe_now, capture_inset, discard, inset_now, input ready);
    modport sink   (input valid, probe_now, capture_inset, discard, inset_now, output ready);
endinterface

// Configuration write channel.
interface bbit_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bbit_pkg::CFG_IDX_W-1:0]  index;
    logic [bbit_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/bbit_cfg_regs.sv]
`default_nettype none

module bbit_cfg_regs (
    input  wire             i_clk,
    input  wire             i_rst_n,
    bbit_cfg_if.sink        i_cfg,
    output bbit_pkg::t_cfg  o_cfg
);

    bbit_pkg::t_cfg r_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.black_threshold   <= bbit_pkg::RST_BLACK_THRESHOLD;
            r_cfg.content_threshold <= bbit_pkg::RST_CONTENT_THRESHOLD;
            r_cfg.initial_streak    <= bbit_pkg::RST_INITIAL_STREAK;
            r_cfg.walking_streak    <= bbit_pkg::RST_WALKING_STREAK;
            r_cfg.step_size         <= bbit_pkg::RST_STEP_SIZE;
            r_cfg.row_limit         <= bbit_pkg::RST_ROW_LIMIT;
            r_cfg.column_limit      <= bbit_pkg::RST_COLUMN_LIMIT;
            r_cfg.probe_period      <= bbit_pkg::RST_PROBE_PERIOD;
        end else if (i_cfg.valid) begin
            unique case (bbit_pkg::t_reg_idx'(i_cfg.index))
                bbit_pkg::REG_BLACK_THRESHOLD:   r_cfg.black_threshold   <= i_cfg.data;
                bbit_pkg::REG_CONTENT_THRESHOLD: r_cfg.content_threshold <= i_cfg.data;
                bbit_pkg::REG_INITIAL_STREAK: begin
                    r_cfg.initial_streak <= i_cfg.data[bbit_pkg::RUN_W-1:0];
                end
                bbit_pkg::REG_WALKING_STREAK: begin
                    r_cfg.walking_streak <= i_cfg.data[bbit_pkg::RUN_W-1:0];
                end
                bbit_pkg::REG_STEP_SIZE:    r_cfg.step_size    <= i_cfg.data;
                bbit_pkg::REG_ROW_LIMIT:    r_cfg.row_limit    <= i_cfg.data;
                bbit_pkg::REG_COLUMN_LIMIT: r_cfg.column_limit <= i_cfg.data;
                bbit_pkg::REG_PROBE_PERIOD: r_cfg.probe_period <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/bbit_edge_calc.sv]
`default_nettype none

module bbit_edge_calc (
    input  wire bbit_pkg::t_item        i_item,
    input  wire bbit_pkg::t_cfg         i_cfg,
    input  wire bbit_pkg::t_edge_vec    i_state,
    output bbit_pkg::t_result           o_result,
    output bbit_pkg::t_edge_state       o_state
);

    bbit_pkg::t_edge_state       cur;
    logic                        black;
    logic                        content_seen;
    logic [7:0]                  limit;
    logic [8:0]                  count_inc;
    logic [bbit_pkg::RUN_W-1:0]  needed;
    logic [bbit_pkg::RUN_W-1:0]  run_inc;
    logic [8:0]                  grown;
    logic                        probe;

    // Shared terms of the edge update.
    always_comb begin
        cur   = i_state[i_item.edge_req];
        black = (i_item.peak_level <= i_cfg.black_threshold);
        content_seen = 1'b0;
        for (int o = 0; o < bbit_pkg::EDGE_TOTAL; o++) begin
            if ((bbit_pkg::EDGE_W'(o) != i_item.edge_req)
                    && (i_state[o].level >= i_cfg.content_threshold)) begin
                content_seen = 1'b1;
            end
        end
        limit = ((i_item.edge_req == bbit_pkg::SIDE_TOP)
                 || (i_item.edge_req == bbit_pkg::SIDE_BOTTOM))
                ? i_cfg.row_limit : i_cfg.column_limit;
        count_inc = {1'b0, cur.count} + 9'd1;
        needed    = cur.walking ? i_cfg.walking_streak : i_cfg.initial_streak;
        run_inc   = (cur.run != bbit_pkg::RUN_MAX) ? cur.run + 1'b1 : cur.run;
        grown     = {1'b0, cur.inset} + {1'b0, i_cfg.step_size};
    end

    // Next state of the addressed edge and the result word.
    always_comb begin
        o_state  = cur;
        o_result = '0;
        probe    = 1'b0;
        if (i_item.cmd == bbit_pkg::CMD_PLAN) begin
            // The capture counter wraps at the probe period.
            if (count_inc >= {1'b0, i_cfg.probe_period}) begin
                o_state.count = '0;
            end else begin
                o_state.count = count_inc[7:0];
            end
            probe = (cur.inset != '0) && (o_state.count == '0);
            o_result.probe_now     = probe;
            o_result.capture_inset = probe ? 8'd0 : cur.inset;
        end else begin
            o_result.probe_now = i_item.probe_flag;
            if (i_item.probe_flag) begin
                // A black probe is dropped; content at the edge clears it.
                if (black) begin
                    o_result.discard = 1'b1;
                end else begin
                    o_state.inset   = '0;
                    o_state.run     = '0;
                    o_state.walking = 1'b0;
                    o_state.level   = i_item.peak_level;
                end
            end else begin
                o_state.level = i_item.peak_level;
                if (black && content_seen && (limit != '0)) begin
                    if (run_inc >= needed) begin
                        o_state.run = '0;
                        if (grown <= {1'b0, limit}) begin
                            o_state.inset   = grown[7:0];
                            o_state.walking = 1'b1;
                        end else begin
                            o_state.inset   = '0;
                            o_state.walking = 1'b0;
                        end
                    end else begin
                        o_state.run = run_inc;
                    end
                end else begin
                    o_state.run = '0;
                    if (!black) begin
                        o_state.walking = 1'b0;
                    end
                end
            end
        end
        o_result.inset_now = o_state.inset;
    end

endmodule

`default_nettype wire

[design/black_border_inset_tracker.sv]
// An accepted word is held first in the input register and then in the result
// register, from which it is presented as a result.
// Throughput: one word per cycle while the result side is ready; the edge update
// is a single pass of logic between the input register and the result register.
// Reset clears all per-edge state, empties both registers and returns the
// configuration registers to their default values. No clearing pass is needed.
`default_nettype none

module black_border_inset_tracker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bbit_item_if.sink   i_item,
    bbit_cfg_if.sink    i_cfg,
    bbit_result_if.source o_result
);

    bbit_pkg::t_cfg        w_cfg;
    bbit_pkg::t_result     w_calc_result;
    bbit_pkg::t_edge_state w_calc_state;
    logic                  w_adv;

    logic                  r_in_valid;
    bbit_pkg::t_item       r_in;
    logic                  r_out_valid;
    bbit_pkg::t_result     r_out;
    bbit_pkg::t_edge_vec   r_state;

    bbit_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    bbit_edge_calc u_edge_calc (
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .o_result (w_calc_result),
        .o_state  (w_calc_state)
    );

    // The held word moves on when the result register is free or being read.
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;

    // Control and per-edge state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_adv) begin
                r_out_valid              <= 1'b1;
                r_state[r_in.edge_req]   <= w_calc_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.cmd        <= i_item.cmd;
            r_in.edge_req   <= i_item.edge_req;
            r_in.probe_flag <= i_item.probe_flag;
            r_in.peak_level <= i_item.peak_level;
        end
        if (w_adv) begin
            r_out <= w_calc_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.probe_now     = r_out.probe_now;
    assign o_result.capture_inset = r_out.capture_inset;
    assign o_result.discard       = r_out.discard;
    assign o_result.inset_now     = r_out.inset_now;

    // A discarded word is always a probe capture and never carries an inset to use.
    a_discard_is_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.discard) |-> (r_out.probe_now && (r_out.capture_inset == '0)))
        else $error("discard without probe");

    // A probing word never asks for a capture away from the edge.
    a_probe_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.probe_now) |-> (r_out.capture_inset == '0))
        else $error("probe with nonzero capture inset");

    // Both registers are empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

    // A held word that cannot move blocks the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("input taken while stalled");

endmodule

`default_nettype wire
